// File: hw/rtl/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// lrukv_pkg: shared types for the lru key-value cache
// Field widths, request/response structs and the mode code.
// ----------------------------------------------------------------------------
`default_nettype none

package lrukv_pkg;

  localparam int unsigned KEY_W      = 32;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned IN_DATA_W  = KEY_W + VALUE_W;   // 96, whole bytes
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = VALUE_W + KEY_W;   // 96, whole bytes
  localparam int unsigned OUT_USER_W = 2;

  // request kind carried on tuser
  typedef enum logic {
    MODE_LOOKUP = 1'b0,
    MODE_INSERT = 1'b1
  } mode_e;

  // one request as held in the input register
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [KEY_W-1:0]   key;
    mode_e              mode;
  } req_t;

  // one result as held in the output register
  typedef struct packed {
    logic [KEY_W-1:0]   evicted_key;
    logic               evicted;
    logic [VALUE_W-1:0] read_value;
    logic               hit;
  } rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/lrukv_match.sv
// ----------------------------------------------------------------------------
// lrukv_match: parallel key compare and victim select
// Compares the request key against every filled entry and finds the
// least recent entry of a full cache.
// ----------------------------------------------------------------------------
`default_nettype none

module lrukv_match #(
  parameter int unsigned CAPACITY = 8
) (
  input  wire logic [lrukv_pkg::KEY_W-1:0]                 key_i,
  input  wire logic [lrukv_pkg::KEY_W-1:0]                 keys_i   [CAPACITY],
  input  wire logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ages_i [CAPACITY],
  input  wire logic [$clog2(CAPACITY + 1)-1:0]             fill_i,
  output logic                                             hit_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] hit_slot_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] victim_o,
  output logic [CAPACITY-1:0]                              filled_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] OldestAge = AW'(CAPACITY - 1);

  logic [CAPACITY-1:0] match;

  // filled slots and per-entry key compare
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      filled_o[i] = CW'(i) < fill_i;
      match[i]    = filled_o[i] && (keys_i[i] == key_i);
    end
  end

  // lowest matching slot; the oldest age is unique once the cache is full
  always_comb begin
    hit_o      = |match;
    hit_slot_o = '0;
    victim_o   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot_o = AW'(i);
      end
      if (ages_i[i] == OldestAge) begin
        victim_o = AW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lrukv_store.sv
// ----------------------------------------------------------------------------
// lrukv_store: entry storage and recency update
// Holds keys, values, ages and the fill count, forms the response for the
// current request and commits the state change when told to.
// ----------------------------------------------------------------------------
`default_nettype none

module lrukv_store #(
  parameter int unsigned CAPACITY = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              commit_i,
  input  wire lrukv_pkg::req_t   req_i,
  output lrukv_pkg::rsp_t        rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] OldestAge = AW'(CAPACITY - 1);

  logic [lrukv_pkg::KEY_W-1:0]   keys_q   [CAPACITY];
  logic [lrukv_pkg::VALUE_W-1:0] values_q [CAPACITY];
  logic [AW-1:0]                 ages_q   [CAPACITY];
  logic [AW-1:0]                 ages_d   [CAPACITY];
  logic [CW-1:0]                 fill_q, fill_d;

  logic                hit;
  logic [AW-1:0]       hit_slot;
  logic [AW-1:0]       victim;
  logic [CAPACITY-1:0] filled;
  logic                insert;
  logic                full;
  logic                evict;
  logic                append;
  logic                update;
  logic [AW-1:0]       slot;
  logic [CW-1:0]       old_age;

  lrukv_match #(
    .CAPACITY (CAPACITY)
  ) u_match (
    .key_i      (req_i.key),
    .keys_i     (keys_q),
    .ages_i     (ages_q),
    .fill_i     (fill_q),
    .hit_o      (hit),
    .hit_slot_o (hit_slot),
    .victim_o   (victim),
    .filled_o   (filled)
  );

  // decide which slot the request touches and its age before promotion
  always_comb begin
    insert  = req_i.mode == lrukv_pkg::MODE_INSERT;
    full    = fill_q == CW'(CAPACITY);
    evict   = insert && !hit && full;
    append  = insert && !hit && !full;
    update  = hit || insert;
    if (hit) begin
      slot    = hit_slot;
      old_age = CW'(ages_q[hit_slot]);
    end else if (full) begin
      slot    = victim;
      old_age = CW'(OldestAge);
    end else begin
      slot    = fill_q[AW-1:0];
      old_age = fill_q;
    end
    fill_d = append ? fill_q + CW'(1) : fill_q;
  end

  // promotion: younger filled entries age by one, the touched slot goes to zero
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ages_d[i] = ages_q[i];
      if (update) begin
        if (slot == AW'(i)) begin
          ages_d[i] = '0;
        end else if (filled[i] && (CW'(ages_q[i]) < old_age)) begin
          ages_d[i] = ages_q[i] + AW'(1);
        end
      end
    end
  end

  // response for the current request
  always_comb begin
    rsp_o.hit         = hit;
    rsp_o.read_value  = (hit && !insert) ? values_q[hit_slot] : '0;
    rsp_o.evicted     = evict;
    rsp_o.evicted_key = evict ? keys_q[victim] : '0;
  end

  // recency state and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        ages_q[i] <= '0;
      end
    end else if (commit_i) begin
      fill_q <= fill_d;
      ages_q <= ages_d;
    end
  end

  // key and value storage, written on every insert
  always_ff @(posedge clk_i) begin
    if (commit_i && insert) begin
      keys_q[slot]   <= req_i.key;
      values_q[slot] <= req_i.value;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit: fully associative key-value cache, lru replacement
//
// Requests enter on the s_axis channel: tuser selects lookup or insert,
// tdata carries the key and the value. Each request yields exactly one
// response on the m_axis channel: tuser holds the hit and evicted flags,
// tdata the value read on a lookup hit and the key pushed out by an insert.
// A request is registered on acceptance and resolved, once the output
// register is free or draining, by a parallel compare of all CAPACITY
// entries plus an age update; the response is then held in an output
// register. One request per cycle is sustained while the receiver does not stall,
// set by the single compare-and-promote path between the two registers.
// Reset empties the cache (fill count and ages cleared) and drops any
// request in flight. When the receiver stalls, the response stays in the
// output register, one more request waits in the input register, and
// s_axis_tready drops until the response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_unit #(
  parameter int unsigned CAPACITY = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [lrukv_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // key, value
  input  wire logic [lrukv_pkg::IN_USER_W-1:0]  s_axis_tuser,  // mode
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [lrukv_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // read_value, evicted_key
  output logic [lrukv_pkg::OUT_USER_W-1:0]      m_axis_tuser   // hit, evicted
);

  logic            in_valid_q;
  lrukv_pkg::req_t in_req_q;
  logic            out_valid_q;
  lrukv_pkg::rsp_t out_rsp_q;
  lrukv_pkg::rsp_t rsp;
  logic            advance;
  logic            in_take;

  // the held request resolves when the output register is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  lrukv_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (advance),
    .req_i    (in_req_q),
    .rsp_o    (rsp)
  );

  // input and output valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and response payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q.mode  <= lrukv_pkg::mode_e'(s_axis_tuser[0]);
      in_req_q.key   <= s_axis_tdata[lrukv_pkg::KEY_W-1:0];
      in_req_q.value <= s_axis_tdata[lrukv_pkg::IN_DATA_W-1:lrukv_pkg::KEY_W];
    end
    if (advance) begin
      out_rsp_q <= rsp;
    end
  end

  // output packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_rsp_q.evicted_key, out_rsp_q.read_value};
  assign m_axis_tuser  = {out_rsp_q.evicted, out_rsp_q.hit};

endmodule

`default_nettype wire

// File: hw/rtl/lrukv_checker.sv
// ----------------------------------------------------------------------------
// lrukv_checker: port-level checks for the lru key-value cache
// Watches the response channel for held data and consistent flag/field use.
// ----------------------------------------------------------------------------
`default_nettype none

module lrukv_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  input  wire logic [lrukv_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic [lrukv_pkg::OUT_USER_W-1:0] m_axis_tuser
);

  // a stalled response keeps its valid and payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled response changed");

  // a request never both hits and evicts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("hit and evicted both set");

  // read value is zero without a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata[lrukv_pkg::VALUE_W-1:0] == '0)
    else $error("read value without hit");

  // evicted key is zero without an eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |->
      m_axis_tdata[lrukv_pkg::OUT_DATA_W-1:lrukv_pkg::VALUE_W] == '0)
    else $error("evicted key without eviction");

endmodule

bind lru_key_value_cache_unit lrukv_checker u_lrukv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
